// ----- hdl/rpu_pkg.sv -----
package rpu_pkg;

	// Default width of the geometry registers and counters.
	localparam int DIM_BITS_DEF = 16;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Pixel width on the output side.
	localparam int PIX_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE    = 3'd4;

	// Packing modes.
	localparam logic MODE_RAW10 = 1'b0;
	localparam logic MODE_RAW12 = 1'b1;

	// Group lengths in bytes.
	localparam logic [2:0] GLEN_RAW10 = 3'd4;
	localparam logic [2:0] GLEN_RAW12 = 3'd3;

	// Index of the last pixel of a group.
	localparam logic [1:0] LAST_IDX_RAW10 = 2'd2;
	localparam logic [1:0] LAST_IDX_RAW12 = 2'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             run_last;
		logic             line_end;
		logic             frame_end;
	} out_word_t;

endpackage

// ----- hdl/packed_raw_pixel_unpacker.sv -----
// Path: a byte accepted into the input register is decoded from there into the
// pixel buffer, from which its first pixel is offered on the output.
// Throughput: one input byte per cycle and one pixel per cycle; a completed group
// of three (RAW10) or two (RAW12) pixels drains from the buffer while later bytes
// of the next group are taken, so the input stalls only under output backpressure.
// Reset: configuration and frame counters to zero, no frame active, pixel buffer
// and input stage empty.
module packed_raw_pixel_unpacker import rpu_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers and their precomputed quotients.
	logic [DIM_BITS-1:0] start_offset_q;
	logic [DIM_BITS-1:0] line_stride_q;
	logic [DIM_BITS-1:0] frame_width_q;
	logic [DIM_BITS-1:0] frame_height_q;
	logic                pack_mode_q;
	logic [DIM_BITS-1:0] width_div3_q;
	logic [DIM_BITS-1:0] stride_div3_q;

	logic [DIM_BITS-1:0] cfg_dim;
	logic [DIM_BITS-1:0] cfg_dim_div3;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fs_s1;
	logic       adv;

	// Frame state.
	logic                frame_active_q;
	logic [DIM_BITS-1:0] offset_count_q;
	logic [DIM_BITS-1:0] line_byte_count_q;
	logic [DIM_BITS-1:0] line_count_q;
	logic [DIM_BITS-1:0] group_count_q;
	logic [1:0]          byte_in_group_q;
	logic [7:0]          group_bytes_q [3];

	// Decode signals.
	logic                act;
	logic [DIM_BITS-1:0] oc;
	logic [DIM_BITS-1:0] lbc;
	logic [DIM_BITS-1:0] lc;
	logic [DIM_BITS-1:0] gc;
	logic [1:0]          big;
	logic [DIM_BITS-1:0] lbc_inc;
	logic [DIM_BITS-1:0] lc_inc;
	logic [DIM_BITS-1:0] gc_inc;
	logic [DIM_BITS-1:0] pix_per_line;
	logic [DIM_BITS-1:0] fit;
	logic [DIM_BITS-1:0] per_line;
	logic [2:0]          glen;
	logic                emit;
	logic                store;
	logic                nxt_act;
	logic [DIM_BITS-1:0] nxt_oc;
	logic [DIM_BITS-1:0] nxt_lbc;
	logic [DIM_BITS-1:0] nxt_lc;
	logic [DIM_BITS-1:0] nxt_gc;
	logic [1:0]          nxt_big;
	logic                last_group;
	logic                last_line;
	logic [31:0]         w;
	logic [PIX_W-1:0]    pix [3];

	// Pixel buffer holding one decoded group.
	logic             grp_valid_q;
	logic [1:0]       grp_idx_q;
	logic [1:0]       grp_last_idx_q;
	logic             grp_line_end_q;
	logic             grp_frame_end_q;
	logic [PIX_W-1:0] grp_pix_q [3];
	logic             last_pix;
	logic             grp_free;

	// Divide the write data by three for the width and stride registers.
	assign cfg_dim = DIM_BITS'(cfg_wdata);

	rpu_div3 #(.W(DIM_BITS)) u_div3 (
		.x (cfg_dim),
		.q (cfg_dim_div3)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
			line_stride_q  <= '0;
			frame_width_q  <= '0;
			frame_height_q <= '0;
			pack_mode_q    <= MODE_RAW10;
			width_div3_q   <= '0;
			stride_div3_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_OFFSET: start_offset_q <= cfg_dim;
				REG_LINE_STRIDE: begin
					line_stride_q <= cfg_dim;
					stride_div3_q <= cfg_dim_div3;
				end
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_dim;
					width_div3_q  <= cfg_dim_div3;
				end
				REG_FRAME_HEIGHT: frame_height_q <= cfg_dim;
				REG_PACK_MODE: pack_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input register; it takes a new word whenever its content moves on.
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data.data_byte;
			fs_s1   <= in_data.frame_start;
		end
	end

	// Groups per line: the pixel limit or the stride limit, whichever is smaller.
	assign glen         = (pack_mode_q == MODE_RAW12) ? GLEN_RAW12 : GLEN_RAW10;
	assign pix_per_line = (pack_mode_q == MODE_RAW12) ? (frame_width_q >> 1) : width_div3_q;
	assign fit          = (pack_mode_q == MODE_RAW12) ? stride_div3_q : (line_stride_q >> 2);
	assign per_line     = (fit < pix_per_line) ? fit : pix_per_line;

	// A frame start clears the counters before this byte is counted.
	always_comb begin
		act = frame_active_q;
		oc  = offset_count_q;
		lbc = line_byte_count_q;
		lc  = line_count_q;
		gc  = group_count_q;
		big = byte_in_group_q;
		if (fs_s1) begin
			act = 1'b1;
			oc  = '0;
			lbc = '0;
			lc  = '0;
			gc  = '0;
			big = 2'd0;
		end
	end

	assign lbc_inc    = lbc + DIM_BITS'(1);
	assign lc_inc     = lc + DIM_BITS'(1);
	assign gc_inc     = gc + DIM_BITS'(1);
	assign last_group = (gc_inc == per_line);
	assign last_line  = (lc_inc == frame_height_q);

	// Byte decode: skip the offset, collect group bytes, step the line counters.
	always_comb begin
		nxt_act = act;
		nxt_oc  = oc;
		nxt_lbc = lbc;
		nxt_lc  = lc;
		nxt_gc  = gc;
		nxt_big = big;
		emit    = 1'b0;
		store   = 1'b0;
		if (act) begin
			if (oc < start_offset_q) begin
				nxt_oc = oc + DIM_BITS'(1);
			end else if (lc >= frame_height_q || line_stride_q == '0) begin
				nxt_act = 1'b0;
			end else begin
				if (gc < per_line) begin
					if (({1'b0, big} + 3'd1) >= glen) begin
						emit    = 1'b1;
						nxt_gc  = gc_inc;
						nxt_big = 2'd0;
					end else begin
						store   = 1'b1;
						nxt_big = big + 2'd1;
					end
				end
				if (lbc_inc >= line_stride_q) begin
					nxt_lbc = '0;
					nxt_gc  = '0;
					nxt_big = 2'd0;
					nxt_lc  = lc_inc;
					if (lc_inc >= frame_height_q) begin
						nxt_act = 1'b0;
					end
				end else begin
					nxt_lbc = lbc_inc;
				end
			end
		end
	end

	// Pixel extraction from the stored bytes and the arriving last byte.
	assign w = {byte_s1, group_bytes_q[2], group_bytes_q[1], group_bytes_q[0]};

	always_comb begin
		if (pack_mode_q == MODE_RAW12) begin
			pix[0] = {group_bytes_q[1][3:0], byte_s1[7:2], 6'd0};
			pix[1] = {group_bytes_q[0], group_bytes_q[1][7:6], 6'd0};
			pix[2] = '0;
		end else begin
			pix[0] = {w[9:0], 6'd0};
			pix[1] = {w[19:10], 6'd0};
			pix[2] = {w[29:20], 6'd0};
		end
	end

	// The stage advances unless a finished group finds the buffer still busy.
	assign last_pix = (grp_idx_q == grp_last_idx_q);
	assign grp_free = !grp_valid_q || (out_ready && last_pix);
	assign adv      = valid_s1 && (!emit || grp_free);

	// Frame state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q    <= 1'b0;
			offset_count_q    <= '0;
			line_byte_count_q <= '0;
			line_count_q      <= '0;
			group_count_q     <= '0;
			byte_in_group_q   <= 2'd0;
		end else if (adv) begin
			frame_active_q    <= nxt_act;
			offset_count_q    <= nxt_oc;
			line_byte_count_q <= nxt_lbc;
			line_count_q      <= nxt_lc;
			group_count_q     <= nxt_gc;
			byte_in_group_q   <= nxt_big;
		end
	end

	// Group byte storage; entries are always written before they are read.
	always_ff @(posedge clk) begin
		if (adv && store) begin
			group_bytes_q[big] <= byte_s1;
		end
	end

	// Pixel buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			grp_idx_q   <= 2'd0;
		end else if (adv && emit) begin
			grp_valid_q <= 1'b1;
			grp_idx_q   <= 2'd0;
		end else if (out_valid && out_ready) begin
			if (last_pix) begin
				grp_valid_q <= 1'b0;
			end else begin
				grp_idx_q <= grp_idx_q + 2'd1;
			end
		end
	end

	// Pixel buffer payload.
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			grp_pix_q[0]    <= pix[0];
			grp_pix_q[1]    <= pix[1];
			grp_pix_q[2]    <= pix[2];
			grp_last_idx_q  <= (pack_mode_q == MODE_RAW12) ? LAST_IDX_RAW12 : LAST_IDX_RAW10;
			grp_line_end_q  <= last_group;
			grp_frame_end_q <= last_group && last_line;
		end
	end

	// Output word; the flags belong to the group's last pixel only.
	assign out_valid = grp_valid_q;

	always_comb begin
		case (grp_idx_q)
			2'd0:    out_data.pixel_value = grp_pix_q[0];
			2'd1:    out_data.pixel_value = grp_pix_q[1];
			default: out_data.pixel_value = grp_pix_q[2];
		endcase
		out_data.run_last  = last_pix;
		out_data.line_end  = last_pix && grp_line_end_q;
		out_data.frame_end = last_pix && grp_frame_end_q;
	end

	// A buffered group has two or three pixels and its read pointer stays inside.
	assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_q |-> ((grp_last_idx_q == LAST_IDX_RAW10 || grp_last_idx_q == LAST_IDX_RAW12)
			&& grp_idx_q <= grp_last_idx_q))
		else $error("pixel buffer pointer out of range");

	// A frame end always closes a line and a group's run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_end) |-> (out_data.line_end && out_data.run_last))
		else $error("frame end without line end");

	// Every pixel is left aligned with zero low bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pixel_value[5:0] == 6'd0))
		else $error("pixel low bits not zero");

	// A byte held back by a busy buffer stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(fs_s1)))
		else $error("stalled input byte lost");

endmodule

// ----- hdl/rpu_div3.sv -----
module rpu_div3 import rpu_pkg::*; #(
	parameter int W = DIM_BITS_DEF
) (
	input  logic [W-1:0] x,
	output logic [W-1:0] q
);

	// Reciprocal of three rounded up, scaled by 2^(W+1). With this rounding the
	// truncated product is the exact quotient for every W-bit dividend.
	localparam longint unsigned MAGIC = ((64'd1 << (W + 1)) + 64'd2) / 64'd3;
	localparam logic [W-1:0] RECIP = W'(MAGIC);

	logic [2*W-1:0] prod;

	// One multiplication, then keep the bits above the scale point.
	assign prod = {{W{1'b0}}, x} * {{W{1'b0}}, RECIP};
	assign q = {1'b0, prod[2*W-1:W+1]};

endmodule

// ----- test/packed_raw_pixel_unpacker_test.sv -----
`timescale 1ns / 100ps

module packed_raw_pixel_unpacker_test;
	import rpu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD_CYCLES = 400;

	// Expected pixel stream, worked out byte by byte from the unpacking rules.
	class pixel_scoreboard;
		logic [15:0] start_offset;
		logic [15:0] line_stride;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic        pack_mode;

		logic [15:0] offset_count;
		logic [15:0] line_byte_count;
		logic [15:0] line_count;
		logic [15:0] group_count;
		logic [7:0]  group_bytes [3];
		logic [1:0]  byte_in_group;
		bit          frame_active;

		out_word_t pixels_due [$];
		int live_bytes;
		int pixels_predicted;
		int errors;

		function new();
			start_offset = '0;
			line_stride = '0;
			frame_width = '0;
			frame_height = '0;
			pack_mode = MODE_RAW10;
			clear_counters();
			foreach (group_bytes[i]) group_bytes[i] = '0;
			frame_active = 0;
			live_bytes = 0;
			pixels_predicted = 0;
			errors = 0;
		endfunction

		function void clear_counters();
			offset_count = '0;
			line_byte_count = '0;
			line_count = '0;
			group_count = '0;
			byte_in_group = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_START_OFFSET: start_offset = val;
				REG_LINE_STRIDE:  line_stride = val;
				REG_FRAME_WIDTH:  frame_width = val;
				REG_FRAME_HEIGHT: frame_height = val;
				REG_PACK_MODE:    pack_mode = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction

		// Note one accepted input word and queue the pixels it completes.
		function void note_byte(in_word_t w);
			int unsigned glen;
			int unsigned per_line;
			int unsigned fit;
			int          n;
			logic [15:0] pix [3];
			logic [31:0] packed_group;
			bit          last_group;
			bit          last_line;
			out_word_t   px;

			n = 0;
			if (w.frame_start) begin
				clear_counters();
				frame_active = 1;
			end
			if (!frame_active) return;
			live_bytes++;

			// Leading bytes of the frame are skipped.
			if (offset_count < start_offset) begin
				offset_count++;
				return;
			end
			if (line_count >= frame_height || line_stride == 0) begin
				frame_active = 0;
				return;
			end

			glen = (pack_mode == MODE_RAW12) ? GLEN_RAW12 : GLEN_RAW10;
			per_line = (pack_mode == MODE_RAW12) ? frame_width / 2 : frame_width / 3;
			fit = line_stride / glen;
			if (fit < per_line) per_line = fit;

			if (group_count < per_line) begin
				if (int'(byte_in_group) + 1 >= glen) begin
					// The arriving byte closes the group.
					if (pack_mode == MODE_RAW12) begin
						pix[0] = {group_bytes[1][3:0], w.data_byte[7:2], 6'b0};
						pix[1] = {group_bytes[0], group_bytes[1][7:6], 6'b0};
						n = 2;
					end else begin
						packed_group = {w.data_byte, group_bytes[2], group_bytes[1],
							group_bytes[0]};
						pix[0] = {packed_group[9:0], 6'b0};
						pix[1] = {packed_group[19:10], 6'b0};
						pix[2] = {packed_group[29:20], 6'b0};
						n = 3;
					end
					last_group = (int'(group_count) + 1 == per_line);
					last_line = (int'(line_count) + 1 == int'(frame_height));
					for (int k = 0; k < n; k++) begin
						px.pixel_value = pix[k];
						px.run_last = (k == n - 1);
						px.line_end = (k == n - 1) && last_group;
						px.frame_end = (k == n - 1) && last_group && last_line;
						pixels_due.push_back(px);
						pixels_predicted++;
					end
					group_count++;
					byte_in_group = '0;
				end else begin
					group_bytes[byte_in_group] = w.data_byte;
					byte_in_group++;
				end
			end

			// Line bookkeeping, including the padding bytes.
			line_byte_count++;
			if (line_byte_count >= line_stride) begin
				line_byte_count = '0;
				group_count = '0;
				byte_in_group = '0;
				line_count++;
				if (line_count >= frame_height) frame_active = 0;
			end
		endfunction

		// Compare one accepted output word with the oldest expected pixel.
		function void check_pixel(out_word_t got);
			out_word_t want;

			if (pixels_due.size() == 0) begin
				$error("pixel_value: expected no word, got %h", got.pixel_value);
				errors++;
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_value !== want.pixel_value) begin
				$error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.line_end !== want.line_end) begin
				$error("line_end: expected %b, got %b", want.line_end, got.line_end);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	pixel_scoreboard sb;
	bit long_hold_req = 1'b0;
	int burst_left = 0;
	int cycles = 0;

	packed_raw_pixel_unpacker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one input word at the current falling edge and hold it until accepted.
	// The sender runs in bursts; a gap of random length, possibly none, follows each burst.
	task automatic push_byte(input logic [7:0] data, input logic start);
		in_word_t w;
		int gap;

		w.data_byte = data;
		w.frame_start = start;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(w);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Stop offering words and wait until every expected pixel has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Rewrite the whole register set; called only while the block is idle.
	task automatic set_config(input logic [15:0] offs, input logic [15:0] stride,
		input logic [15:0] width, input logic [15:0] height, input logic mode);
		write_reg(REG_START_OFFSET, offs);
		write_reg(REG_LINE_STRIDE, stride);
		write_reg(REG_FRAME_WIDTH, width);
		write_reg(REG_FRAME_HEIGHT, height);
		write_reg(REG_PACK_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
		cfg_we <= 1'b0;
	endtask

	// Check every pixel word as it is accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_pixel(out_data);
	end

	// Receiver: stall segments of random kind and length, plus one long hold-off.
	initial begin : receiver
		int seg_left;
		int seg_kind;

		seg_left = 0;
		seg_kind = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 2);
					seg_left = $urandom_range(1, 40);
				end
				seg_left--;
				case (seg_kind)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(negedge clk);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int live_goal;
		int pixel_goal;
		int n_frames;
		int len;
		logic [15:0] offs;
		logic [15:0] stride;
		logic [15:0] width;
		logic [15:0] height;
		logic        mode;

		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// All registers zero: idle byte ignored, zero stride ends the frame at once.
		set_config(16'd0, 16'd0, 16'd0, 16'd0, MODE_RAW10);
		push_byte(8'hA5, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		drain();

		// RAW10 over two lines with one skipped byte; a byte after the frame is ignored.
		set_config(16'd1, 16'd4, 16'd3, 16'd2, MODE_RAW10);
		push_byte(8'h11, 1'b1);
		repeat (4) push_byte(8'hFF, 1'b0);
		repeat (4) push_byte(8'h00, 1'b0);
		push_byte(8'h5A, 1'b0);
		drain();

		// RAW12 with the widest width and height, so the stride limits the groups.
		// The frame is left with a partial group.
		set_config(16'd0, 16'd3, 16'hFFFF, 16'hFFFF, MODE_RAW12);
		push_byte(8'hAB, 1'b1);
		push_byte(8'hCD, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		drain();

		// Mode switches to RAW10 in mid group, then a frame start restarts mid frame.
		set_config(16'd0, 16'd8, 16'd3, 16'hFFFF, MODE_RAW10);
		push_byte(8'h56, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(8'h9C, 1'b1);
		drain();

		// Largest offset and stride: every byte falls in the skipped region.
		set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, MODE_RAW12);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h3C, 1'b0);
		drain();

		// Random frames, mostly well formed, with the long receiver hold-off early on.
		live_goal = sb.live_bytes + 200;
		pixel_goal = sb.pixels_predicted + 48;
		long_hold_req = 1'b1;
		while (sb.live_bytes < live_goal || sb.pixels_predicted < pixel_goal) begin
			offs = 16'($urandom_range(0, 3));
			stride = 16'($urandom_range(1, 15));
			width = 16'($urandom_range(0, 12));
			height = 16'($urandom_range(1, 3));
			mode = $urandom_range(0, 1) ? MODE_RAW12 : MODE_RAW10;
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: stride = 16'd0;
					1: height = 16'd0;
					2: width = 16'hFFFF;
					default: height = 16'hFFFF;
				endcase
			end
			set_config(offs, stride, width, height, mode);

			n_frames = $urandom_range(1, 3);
			repeat (n_frames) begin
				// Occasional noise ahead of the frame start.
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
				end
				len = int'(offs) + int'(stride) * int'(height) + $urandom_range(0, 3);
				if (len > 80) len = 80;
				if (len < 1) len = 1;
				push_byte(8'($urandom_range(0, 255)), 1'b1);
				for (int j = 1; j < len; j++) begin
					push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
				end
			end
			drain();
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
